// ===== rtl/assert_macros.svh =====
// assertion macros used by circle_tangent_snap
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== rtl/cts_pkg.sv =====
// types and constants for the circle tangent snap pipeline
// no dependencies
`timescale 1ns / 1ps
package cts_pkg;
    localparam int COORD_W = 16;
    localparam int RAD_W = 15;
    localparam int CAP_W = 8;
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd30;
endpackage

// ===== rtl/cts_sqrt_pipe.sv =====
// pipelined integer square root, two result bits per stage
// depends on nothing
`timescale 1ns / 1ps
module cts_sqrt_pipe #(
    parameter int IN_W = 36,
    parameter int DW = 64
) (
    input  logic            i_clk,
    input  logic [IN_W-1:0] i_val,
    input  logic [DW-1:0]   i_data,
    output logic [IN_W/2-1:0] o_root,
    output logic [DW-1:0]   o_data
);
    localparam int N = IN_W / 2;
    localparam int SPS = 2;
    localparam int NST = (N + SPS - 1) / SPS;

    logic [IN_W-1:0] r_rem [NST+1];
    logic [N-1:0]    r_res [NST+1];
    logic [IN_W-1:0] r_v   [NST+1];
    logic [DW-1:0]   r_d   [NST+1];

    always_comb begin
        r_rem[0] = '0;
        r_res[0] = '0;
        r_v[0]   = i_val;
        r_d[0]   = i_data;
    end

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [IN_W-1:0] n_rem;
        logic [N-1:0]    n_res;
        always_comb begin
            logic [IN_W+1:0] rem;
            logic [IN_W+1:0] trial;
            int b;
            rem   = {2'b00, r_rem[s]};
            trial = '0;
            n_res = r_res[s];
            for (int k = 0; k < SPS; k++) begin
                b = N - 1 - (s * SPS + k);
                if (b >= 0) begin
                    rem = {rem[IN_W-1:0], r_v[s][2*b+1 -: 2]};
                    trial = {2'b00, n_res, 2'b01};
                    n_res = n_res << 1;
                    if (rem >= trial) begin
                        rem = rem - trial;
                        n_res[0] = 1'b1;
                    end
                end
            end
            n_rem = rem[IN_W-1:0];
        end
        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= n_rem;
            r_res[s+1] <= n_res;
            r_v[s+1]   <= r_v[s];
            r_d[s+1]   <= r_d[s];
        end
    end

    assign o_root = r_res[NST];
    assign o_data = r_d[NST];
endmodule

// ===== rtl/cts_div_pipe.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on nothing
`timescale 1ns / 1ps
module cts_div_pipe #(
    parameter int NW = 52,
    parameter int DVW = 35,
    parameter int QW = 19
) (
    input  logic           i_clk,
    input  logic [NW-1:0]  i_num,
    input  logic [DVW-1:0] i_den,
    output logic [QW-1:0]  o_quo
);
    // quotient assumed to fit in QW bits
    logic [NW-1:0]  r_rem [QW+1];
    logic [DVW-1:0] r_den [QW+1];
    logic [QW-1:0]  r_q   [QW+1];

    always_comb begin
        r_rem[0] = i_num;
        r_den[0] = i_den;
        r_q[0]   = '0;
    end

    for (genvar s = 0; s < QW; s++) begin : g_st
        localparam int B = QW - 1 - s;
        logic [NW+QW:0] sh;
        logic           ge;
        assign sh = {{(NW+QW+1-DVW){1'b0}}, r_den[s]} << B;
        assign ge = {{(QW+1){1'b0}}, r_rem[s]} >= sh;
        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= ge ? NW'({{(QW+1){1'b0}}, r_rem[s]} - sh) : r_rem[s];
            r_den[s+1] <= r_den[s];
            r_q[s+1]   <= r_q[s] | (QW'(ge) << B);
        end
    end

    assign o_quo = r_q[QW];
endmodule

// ===== rtl/circle_tangent_snap.sv =====
// circle tangent snap top level: tangent points and cursor capture test
// depends on cts_pkg, cts_sqrt_pipe, cts_div_pipe, assert_macros.svh
//
// channel   | ports                          | handshake
// ----------+--------------------------------+---------------------
// request   | i_from_*, i_center_*, i_radius | start & !busy
//           | i_ptr_*                        |
// result    | o_tangent_*, o_in_range        | o_done (one cycle)
//           | o_no_tangent                   |
// config    | i_cfg_data                     | i_cfg_we
//
// one request per clock; o_done flags each result after the stages below:
// 3 front stages, 9 square root stages, 4 product and rounding stages,
// 20 divider stages and 3 back stages
// busy is always low; the receiver cannot stall, so nothing waits
// synchronous active-low reset clears valid bits and sets capture to 30
`timescale 1ns / 1ps
`include "assert_macros.svh"
module circle_tangent_snap import cts_pkg::*; #(
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_from_x,
    input  logic signed [COORD_W-1:0] i_from_y,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic        [RAD_W-1:0]   i_radius,
    input  logic signed [COORD_W-1:0] i_ptr_x,
    input  logic signed [COORD_W-1:0] i_ptr_y,
    input  logic                      i_cfg_we,
    input  logic        [CAP_W-1:0]   i_cfg_data,
    output logic                      o_done,
    output logic signed [COORD_W-1:0] o_tangent_x,
    output logic signed [COORD_W-1:0] o_tangent_y,
    output logic                      o_in_range,
    output logic                      o_no_tangent
);
    localparam int SQ_IN = 36;
    localparam int SQ_W = SQ_IN / 2;
    localparam int SQ_ST = (SQ_W + 1) / 2;
    localparam int NUM_W = 52;
    localparam int DEN_W = 35;
    localparam int QW = 20;
    localparam int LIM_W = CAP_W + COORD_FRAC_BITS;

    typedef struct packed {
        logic                      nt;
        logic signed [COORD_W-1:0] hx, hy, cx, cy;
    } t_side;

    assign busy = 1'b0;

    logic [CAP_W-1:0] r_cap;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap <= CAP_RESET;
        else if (i_cfg_we) r_cap <= i_cfg_data;
    end

    // stage 1: differences; stage 2: squares
    logic               r1_v;
    t_side              r1_sd;
    logic signed [16:0] r1_x, r1_y;
    logic [RAD_W-1:0]   r1_r;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else r1_v <= start;
        r1_x <= 17'(i_from_x) - 17'(i_center_x);
        r1_y <= 17'(i_from_y) - 17'(i_center_y);
        r1_r <= i_radius;
        r1_sd <= '{nt: 1'b0, hx: i_center_x, hy: i_center_y,
                   cx: i_ptr_x, cy: i_ptr_y};
    end

    logic               r2_v;
    t_side              r2_sd;
    logic signed [16:0] r2_x, r2_y;
    logic [RAD_W-1:0]   r2_r;
    logic [33:0]        r2_xx, r2_yy;
    logic [29:0]        r2_rr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else r2_v <= r1_v;
        r2_xx <= 34'(r1_x * r1_x);
        r2_yy <= 34'(r1_y * r1_y);
        r2_rr <= r1_r * r1_r;
        r2_x <= r1_x; r2_y <= r1_y; r2_r <= r1_r; r2_sd <= r1_sd;
    end

    logic               r3_v;
    t_side              r3_sd;
    logic signed [16:0] r3_x, r3_y;
    logic [RAD_W-1:0]   r3_r;
    logic [34:0]        r3_c0;
    logic [29:0]        r3_rr;
    logic signed [36:0] r3_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else r3_v <= r2_v;
        r3_c0 <= 35'(r2_xx) + 35'(r2_yy);
        r3_d  <= 37'(r2_xx) + 37'(r2_yy) - 37'(r2_rr);
        r3_rr <= r2_rr;
        r3_x <= r2_x; r3_y <= r2_y; r3_r <= r2_r; r3_sd <= r2_sd;
    end

    // square root of d; d < 2^35 so 36 bits suffice
    localparam int SDW = $bits(t_side) + 17 + 17 + 35 + 30 + RAD_W;
    logic [SQ_IN-1:0] sq_in;
    logic [SQ_W-1:0]  sq_root;
    logic [SDW-1:0]   sq_di, sq_do;
    t_side            sd_side;
    assign sq_in = (r3_d > 0) ? SQ_IN'(r3_d) : '0;
    t_side            sd_in;
    always_comb begin
        sd_in = r3_sd;
        sd_in.nt = !(r3_d > 0);
    end
    assign sq_di = {sd_in, r3_x, r3_y, r3_c0, r3_rr, r3_r};

    logic signed [16:0] s_x, s_y;
    logic [34:0]        s_c0;
    logic [29:0]        s_rr;
    logic [RAD_W-1:0]   s_r;

    cts_sqrt_pipe #(.IN_W(SQ_IN), .DW(SDW)) u_sqrt (
        .i_clk  (i_clk),
        .i_val  (sq_in),
        .i_data (sq_di),
        .o_root (sq_root),
        .o_data (sq_do)
    );
    assign {sd_side, s_x, s_y, s_c0, s_rr, s_r} = sq_do;

    // valid bits through sqrt stages with reset
    logic [SQ_ST-1:0] r_sqv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sqv <= '0;
        else r_sqv <= {r_sqv[SQ_ST-2:0], r3_v};
    end

    // products: r*s first, then by x/y
    logic               r4_v;
    t_side              r4_sd;
    logic signed [16:0] r4_x, r4_y;
    logic [34:0]        r4_c0;
    logic [29:0]        r4_rr;
    logic [32:0]        r4_rs;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else r4_v <= r_sqv[SQ_ST-1];
        r4_rs <= 33'(s_r) * 33'(sq_root);
        r4_x <= s_x; r4_y <= s_y; r4_c0 <= s_c0; r4_rr <= s_rr; r4_sd <= sd_side;
    end

    logic               r5_v;
    t_side              r5_sd;
    logic [34:0]        r5_c0;
    logic signed [49:0] r5_ax, r5_ay, r5_bx, r5_by;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else r5_v <= r4_v;
        r5_ax <= 50'(r4_x) * 50'(signed'({1'b0, r4_rr}));
        r5_ay <= 50'(r4_y) * 50'(signed'({1'b0, r4_rr}));
        r5_bx <= 50'(r4_y) * 50'(signed'({1'b0, r4_rs}));
        r5_by <= 50'(r4_x) * 50'(signed'({1'b0, r4_rs}));
        r5_c0 <= r4_c0; r5_sd <= r4_sd;
    end

    // numerators to magnitude with half-divisor bias
    logic               r6_v;
    t_side              r6_sd;
    logic [34:0]        r6_c0;
    logic signed [NUM_W-1:0] r6_n [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else r6_v <= r5_v;
        r6_n[0] <= NUM_W'(r5_ax) + NUM_W'(r5_bx);
        r6_n[1] <= NUM_W'(r5_ay) - NUM_W'(r5_by);
        r6_n[2] <= NUM_W'(r5_ax) - NUM_W'(r5_bx);
        r6_n[3] <= NUM_W'(r5_ay) + NUM_W'(r5_by);
        r6_c0 <= r5_c0; r6_sd <= r5_sd;
    end

    logic               r7_v;
    t_side              r7_sd;
    logic [34:0]        r7_c0;
    logic [NUM_W-1:0]   r7_m [4];
    logic [3:0]         r7_neg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else r7_v <= r6_v;
        for (int k = 0; k < 4; k++) begin
            r7_neg[k] <= r6_n[k][NUM_W-1];
            r7_m[k] <= (r6_n[k][NUM_W-1] ? NUM_W'(-r6_n[k]) : NUM_W'(r6_n[k]))
                       + NUM_W'(r6_c0 >> 1);
        end
        r7_c0 <= r6_c0; r7_sd <= r6_sd;
    end

    logic [QW-1:0] dq [4];
    for (genvar k = 0; k < 4; k++) begin : g_div
        cts_div_pipe #(.NW(NUM_W), .DVW(DEN_W), .QW(QW)) u_div (
            .i_clk (i_clk),
            .i_num (r7_m[k]),
            .i_den ((r7_c0 == '0) ? DEN_W'(1) : r7_c0),
            .o_quo (dq[k])
        );
    end

    // side data delay line matching the dividers
    logic [QW-1:0] r_dv;
    t_side         r_dsd [QW];
    logic [3:0]    r_dng [QW];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv <= '0;
        else r_dv <= {r_dv[QW-2:0], r7_v};
        r_dsd[0] <= r7_sd;
        r_dng[0] <= r7_neg;
        for (int k = 1; k < QW; k++) begin
            r_dsd[k] <= r_dsd[k-1];
            r_dng[k] <= r_dng[k-1];
        end
    end

    // add centre and saturate
    logic               r8_v;
    t_side              r8_sd;
    logic signed [COORD_W-1:0] r8_p [4];
    t_side q_sd;
    assign q_sd = r_dsd[QW-1];
    always_ff @(posedge i_clk) begin
        logic signed [QW+1:0] t;
        if (!i_rst_n) r8_v <= 1'b0;
        else r8_v <= r_dv[QW-1];
        for (int k = 0; k < 4; k++) begin
            t = r_dng[QW-1][k] ? -(QW+2)'(signed'({1'b0, dq[k]}))
                               : (QW+2)'(signed'({1'b0, dq[k]}));
            t = t + (QW+2)'((k % 2 == 0) ? q_sd.hx : q_sd.hy);
            if (t > 32767) r8_p[k] <= 16'sh7fff;
            else if (t < -32768) r8_p[k] <= 16'sh8000;
            else r8_p[k] <= COORD_W'(t);
        end
        r8_sd <= q_sd;
    end

    // distances to cursor
    logic               r9_v;
    t_side              r9_sd;
    logic signed [COORD_W-1:0] r9_p [4];
    logic [33:0]        r9_sq [4];
    always_ff @(posedge i_clk) begin
        logic signed [16:0] dd;
        if (!i_rst_n) r9_v <= 1'b0;
        else r9_v <= r8_v;
        for (int k = 0; k < 4; k++) begin
            dd = 17'((k % 2 == 0) ? r8_sd.cx : r8_sd.cy) - 17'(r8_p[k]);
            r9_sq[k] <= 34'(dd * dd);
        end
        r9_p <= r8_p; r9_sd <= r8_sd;
    end

    logic [LIM_W-1:0] lim;
    assign lim = LIM_W'(r_cap) << COORD_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        logic [2*LIM_W-1:0] l2;
        logic c0, c1;
        if (!i_rst_n) o_done <= 1'b0;
        else o_done <= r9_v;
        l2 = lim * lim;
        c0 = !r9_sd.nt && ((35'(r9_sq[0]) + 35'(r9_sq[1])) < 35'(l2));
        c1 = !r9_sd.nt && ((35'(r9_sq[2]) + 35'(r9_sq[3])) < 35'(l2));
        o_no_tangent <= r9_sd.nt;
        o_in_range <= c0 || c1;
        o_tangent_x <= c1 ? r9_p[2] : (c0 ? r9_p[0] : '0);
        o_tangent_y <= c1 ? r9_p[3] : (c0 ? r9_p[1] : '0);
    end

    `ASSERT_IMP(a_nt_not_close, i_clk, i_rst_n, o_done && o_no_tangent, !o_in_range)
    `ASSERT_IMP(a_zero_when_far, i_clk, i_rst_n, o_done && !o_in_range,
        o_tangent_x == '0 && o_tangent_y == '0)
    `ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, r9_v, o_done)
endmodule

// ===== dv/circle_tangent_snap_tb.sv =====
// testbench for circle_tangent_snap: directed and random tangent snap requests
// depends on cts_pkg and the circle_tangent_snap rtl; predicts results in a scoreboard class
`timescale 1ns / 1ps

module circle_tangent_snap_tb;
    import cts_pkg::*;

    localparam int FRAC = 4;
    localparam int LATENCY = 60;

    typedef struct packed {
        logic signed [COORD_W-1:0] from_x;
        logic signed [COORD_W-1:0] from_y;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic        [RAD_W-1:0]   radius;
        logic signed [COORD_W-1:0] ptr_x;
        logic signed [COORD_W-1:0] ptr_y;
    } snap_req_t;

    localparam int REQ_W = $bits(snap_req_t);

    typedef struct packed {
        logic signed [COORD_W-1:0] tangent_x;
        logic signed [COORD_W-1:0] tangent_y;
        logic                      in_range;
        logic                      no_tangent;
    } snap_res_t;

    class snap_scoreboard;
        snap_res_t  pending[$];
        logic [7:0] capture;
        int         errors;

        function new();
            capture = CAP_RESET;
            errors = 0;
        endfunction

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        static function longint div_round(longint n, longint d);
            longint unsigned mag;
            longint unsigned q;
            mag = (n < 0) ? longint'(-n) : n;
            q = (mag + longint'(d) / 2) / longint'(d);
            return (n < 0) ? -longint'(q) : longint'(q);
        endfunction

        static function longint clip16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function bit in_capture(longint px, longint py, longint cx, longint cy);
            longint dx;
            longint dy;
            longint unsigned lim;
            dx = cx - px;
            dy = cy - py;
            lim = longint'(capture) << FRAC;
            return longint'(dx * dx + dy * dy) < lim * lim;
        endfunction

        function void note_request(snap_req_t q);
            snap_res_t e;
            longint x, y, c0, rr, d, s, ax, bx, ay, by, hx, hy;
            longint px[2];
            longint py[2];
            e = '0;
            hx = q.center_x;
            hy = q.center_y;
            x = longint'(q.from_x) - hx;
            y = longint'(q.from_y) - hy;
            c0 = x * x + y * y;
            rr = longint'(q.radius) * longint'(q.radius);
            d = c0 - rr;
            if (d <= 0) begin
                e.no_tangent = 1'b1;
            end else begin
                s = int_sqrt(d);
                ax = x * rr;
                bx = y * longint'(q.radius) * s;
                ay = y * rr;
                by = x * longint'(q.radius) * s;
                px[0] = clip16(div_round(ax + bx, c0) + hx);
                py[0] = clip16(div_round(ay - by, c0) + hy);
                px[1] = clip16(div_round(ax - bx, c0) + hx);
                py[1] = clip16(div_round(ay + by, c0) + hy);
                // second point overrides the first when both are close
                for (int i = 0; i < 2; i++) begin
                    if (in_capture(px[i], py[i], q.ptr_x, q.ptr_y)) begin
                        e.tangent_x = px[i][15:0];
                        e.tangent_y = py[i][15:0];
                        e.in_range = 1'b1;
                    end
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(snap_res_t a);
            snap_res_t e;
            if (pending.size() == 0) begin
                $error("unexpected result %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.tangent_x !== e.tangent_x) begin
                $error("tangent_x expected %0d actual %0d", e.tangent_x, a.tangent_x);
                errors++;
            end
            if (a.tangent_y !== e.tangent_y) begin
                $error("tangent_y expected %0d actual %0d", e.tangent_y, a.tangent_y);
                errors++;
            end
            if (a.in_range !== e.in_range) begin
                $error("in_range expected %0b actual %0b", e.in_range, a.in_range);
                errors++;
            end
            if (a.no_tangent !== e.no_tangent) begin
                $error("no_tangent expected %0b actual %0b", e.no_tangent, a.no_tangent);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    snap_req_t req = '0;
    logic i_cfg_we = 1'b0;
    logic [CAP_W-1:0] i_cfg_data = '0;
    logic o_done;
    logic signed [COORD_W-1:0] o_tangent_x;
    logic signed [COORD_W-1:0] o_tangent_y;
    logic o_in_range;
    logic o_no_tangent;

    snap_scoreboard sb = new();
    int n_close = 0;
    int n_none = 0;
    int n_req = 0;

    circle_tangent_snap u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_from_x(req.from_x), .i_from_y(req.from_y),
        .i_center_x(req.center_x), .i_center_y(req.center_y),
        .i_radius(req.radius), .i_ptr_x(req.ptr_x), .i_ptr_y(req.ptr_y),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_tangent_x(o_tangent_x), .o_tangent_y(o_tangent_y),
        .o_in_range(o_in_range), .o_no_tangent(o_no_tangent)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_result({o_tangent_x, o_tangent_y, o_in_range, o_no_tangent});
            if (o_in_range) n_close++;
            if (o_no_tangent) n_none++;
        end
    end

    // start stays high between back to back requests
    task automatic send(snap_req_t q, bit gaps);
        int idle;
        idle = gaps ? $urandom_range(0, 7) : 0;
        if (idle > 0) start <= 1'b0;
        repeat (idle) @(posedge i_clk);
        req <= q;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(q);
        n_req++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic set_capture(logic [7:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.capture = v;
        @(posedge i_clk);
    endtask

    function automatic snap_req_t mk(int fx, int fy, int hx, int hy, int r, int cx, int cy);
        snap_req_t q;
        q.from_x = COORD_W'(fx); q.from_y = COORD_W'(fy);
        q.center_x = COORD_W'(hx); q.center_y = COORD_W'(hy);
        q.radius = RAD_W'(r); q.ptr_x = COORD_W'(cx); q.ptr_y = COORD_W'(cy);
        return q;
    endfunction

    // mostly geometry placed around the circle centre; some with the start point on the centre, the rest fully random
    function automatic snap_req_t rand_req();
        snap_req_t q;
        int kind;
        int span;
        kind = $urandom_range(0, 9);
        q = snap_req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
        if (kind < 7) begin
            span = (kind < 4) ? 4095 : 32767;
            q.center_x = 16'($urandom_range(0, 2 * span) - span);
            q.center_y = 16'($urandom_range(0, 2 * span) - span);
            q.radius = 15'($urandom_range(0, span));
            q.from_x = q.center_x + $signed(16'($urandom_range(0, 2 * span) - span));
            q.from_y = q.center_y + $signed(16'($urandom_range(0, 2 * span) - span));
            q.ptr_x = q.center_x + $signed(16'($urandom_range(0, 2 * span) - span));
            q.ptr_y = q.center_y + $signed(16'($urandom_range(0, 2 * span) - span));
        end else if (kind == 7) begin
            q.from_x = q.center_x;
            q.from_y = q.center_y;
        end
        return q;
    endfunction

    function automatic snap_req_t aimed(snap_req_t q);
        // cursor near the circle rim, where tangent points often lie
        q.ptr_x = q.center_x + q.radius / 2;
        q.ptr_y = q.center_y - q.radius;
        return q;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset capture, extremes, inside circle, both close, saturation
        send(mk(160, 0, 0, 0, 80, 40, 69), 0);
        send(mk(160, 0, 0, 0, 80, 40, -69), 0);
        send(mk(100, 100, 100, 100, 0, 0, 0), 0);
        send(mk(10, 0, 0, 0, 80, 0, 0), 0);
        send(mk(80, 0, 0, 0, 80, 0, 0), 0);
        send(mk(-32768, -32768, 32767, 32767, 32767, 32767, -32768), 0);
        send(mk(32767, 32767, -32768, -32768, 0, 32767, 32767), 0);
        send(mk(32767, 0, 32000, 0, 32767, 32767, 32767), 0);
        send(mk(-32768, 0, -32000, 0, 32767, -32768, -32768), 0);
        send(mk(32, 0, 0, 0, 16, 8, 13), 0);
        send(mk(0, 32767, 0, -32768, 32767, 32767, 0), 0);
        drain();
        set_capture(8'd255);
        send(mk(32, 0, 0, 0, 16, 8, 13), 0);
        send(mk(800, 0, 0, 0, 400, 200, 0), 0);
        send(mk(-32768, 32767, 32767, -32768, 100, 0, 0), 0);
        drain();
        set_capture(8'd0);
        send(mk(160, 0, 0, 0, 80, 40, 69), 0);
        send(mk(32, 0, 0, 0, 16, 8, 13), 0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_capture(8'd1);
                1: set_capture(8'd255);
                2: set_capture(8'd30);
                default: set_capture(8'($urandom_range(0, 255)));
            endcase
            for (int i = 0; i < 180; i++) begin
                snap_req_t q;
                q = rand_req();
                if ($urandom_range(0, 2) == 0) q = aimed(q);
                send(q, (phase % 2) == 0 || i > 90);
                if (phase == 3 && i == 60) drain();
            end
            drain();
        end

        $display("sent %0d requests: %0d captured, %0d without tangent, six capture settings",
                 n_req, n_close, n_none);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
